FILE: sv/fva_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fva_pkg
// Types, constants and helpers shared by the flock velocity alignment block.
// ----------------------------------------------------------------------------
package fva_pkg;

    localparam int ACC_W  = 96;
    localparam int OP_W   = 64;
    localparam int S_W    = 50;
    localparam int POS_W  = 24;
    localparam int LOOK_W = 16;
    localparam int CFG_W  = 23;
    localparam int MAG_W  = 25;
    localparam int LEN_W  = 32;
    localparam int STEP_W = 6;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    localparam logic [1:0] REG_RADIUS  = 2'd0;
    localparam logic [1:0] REG_MIN_DOT = 2'd1;
    localparam logic [1:0] REG_MAX_ACC = 2'd2;

    localparam logic [CFG_W-1:0]         RADIUS_RST  = 23'd2560;
    localparam logic signed [LOOK_W-1:0] MIN_DOT_RST = -16'sd16384;
    localparam logic [CFG_W-1:0]         MAX_ACC_RST = 23'd256;
    localparam logic signed [LOOK_W-1:0] DOT_OFF     = -16'sd16384;

    localparam logic [STEP_W-1:0] DIV_LAST  = 6'd63;
    localparam logic [STEP_W-1:0] SQRT_LAST = 6'd31;

    typedef struct packed {
        logic [CFG_W-1:0]         radius;
        logic signed [LOOK_W-1:0] min_dot;
        logic [CFG_W-1:0]         max_acc;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SQ_SET,
        ST_R2_SET,
        ST_R2_CMP,
        ST_CONE,
        ST_D_SET,
        ST_D_ABS,
        ST_M_SET,
        ST_MS_SET,
        ST_CONE_CMP,
        ST_ACCEPT,
        ST_ITEM_END,
        ST_FIN,
        ST_AVG_SET,
        ST_AVG_DONE,
        ST_MAG_SET,
        ST_A2_SET,
        ST_A2_CMP,
        ST_SQRT_SET,
        ST_SQRT_DONE,
        ST_NUM_SET,
        ST_DIV_SET,
        ST_DIV_DONE,
        ST_EMIT,
        ST_MUL,
        ST_DIV,
        ST_SQRT
    } state_t;

    // saturate a sign/magnitude value to 24 bit two's complement
    function automatic logic [POS_W-1:0] sat_steer(input logic [OP_W-1:0] mag,
                                                   input logic neg);
        logic [OP_W-1:0]  neg_mag;
        logic [POS_W-1:0] r;
        neg_mag = ~mag + 64'd1;
        if (neg)
        begin
            if (mag > 64'd8388608)
                r = 24'h800000;
            else
                r = neg_mag[POS_W-1:0];
        end
        else
        begin
            if (mag > 64'd8388607)
                r = 24'h7FFFFF;
            else
                r = mag[POS_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/fva_addsub.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fva_addsub
// Shared wide adder/subtractor; carry out doubles as unsigned x >= y.
// ----------------------------------------------------------------------------
module fva_addsub (
    input  wire logic [fva_pkg::ACC_W-1:0] x,
    input  wire logic [fva_pkg::ACC_W-1:0] y,
    input  wire logic                      sub,
    output logic [fva_pkg::ACC_W-1:0]      sum,
    output logic                           carry
);
    import fva_pkg::*;

    logic [ACC_W:0] full;

    always_comb
    begin
        full  = {1'b0, x} + {1'b0, (sub ? ~y : y)} + {{ACC_W{1'b0}}, sub};
        sum   = full[ACC_W-1:0];
        carry = full[ACC_W];
    end

endmodule
`default_nettype wire

FILE: sv/fva_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fva_regs
// APB configuration registers: radius, cone threshold, steering cap.
// ----------------------------------------------------------------------------
module fva_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [fva_pkg::ADDR_W-1:0] paddr,
    input  wire logic [fva_pkg::DATA_W-1:0] pwdata,
    output logic [fva_pkg::DATA_W-1:0]      prdata,
    output logic                            pready,
    output fva_pkg::cfg_t                   cfg
);
    import fva_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_RADIUS:  cfg_next.radius  = pwdata[CFG_W-1:0];
                REG_MIN_DOT: cfg_next.min_dot = pwdata[LOOK_W-1:0];
                REG_MAX_ACC: cfg_next.max_acc = pwdata[CFG_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_RADIUS:  prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_reg.radius};
            REG_MIN_DOT: prdata = {{(DATA_W-LOOK_W){1'b0}}, cfg_reg.min_dot};
            REG_MAX_ACC: prdata = {{(DATA_W-CFG_W){1'b0}}, cfg_reg.max_acc};
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius  <= RADIUS_RST;
            cfg_reg.min_dot <= MIN_DOT_RST;
            cfg_reg.max_acc <= MAX_ACC_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

FILE: sv/fva_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fva_core
// Sequencer and datapath: neighbour test and steering built from repeated
// shift-add multiply, restoring divide and bitwise square root steps, all
// on one shared adder.
// ----------------------------------------------------------------------------
module fva_core #(
    parameter int MAX_BOIDS = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire fva_pkg::cfg_t                       cfg,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                mode,
    input  wire logic signed [fva_pkg::POS_W-1:0]    pos_x,
    input  wire logic signed [fva_pkg::POS_W-1:0]    pos_y,
    input  wire logic signed [fva_pkg::POS_W-1:0]    pos_z,
    input  wire logic signed [fva_pkg::POS_W-1:0]    vel_x,
    input  wire logic signed [fva_pkg::POS_W-1:0]    vel_y,
    input  wire logic signed [fva_pkg::POS_W-1:0]    vel_z,
    input  wire logic signed [fva_pkg::LOOK_W-1:0]   look_x,
    input  wire logic signed [fva_pkg::LOOK_W-1:0]   look_y,
    input  wire logic signed [fva_pkg::LOOK_W-1:0]   look_z,
    input  wire logic                                last,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [fva_pkg::POS_W-1:0]         steer_x,
    output logic signed [fva_pkg::POS_W-1:0]         steer_y,
    output logic signed [fva_pkg::POS_W-1:0]         steer_z,
    output logic [$clog2(MAX_BOIDS+1)-1:0]           neighbour_count,
    output logic                                     found
);
    import fva_pkg::*;

    localparam int CNT_W = $clog2(MAX_BOIDS + 1);
    localparam int SUM_W = POS_W + CNT_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BOIDS);

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    logic signed [POS_W-1:0]  own_pos_reg [3], own_pos_next [3];
    logic signed [POS_W-1:0]  own_vel_reg [3], own_vel_next [3];
    logic signed [LOOK_W-1:0] own_look_reg [3], own_look_next [3];
    logic signed [SUM_W-1:0]  vsum_reg [3], vsum_next [3];
    logic [CNT_W-1:0]         cnt_reg, cnt_next;

    logic signed [POS_W-1:0]  cand_vel_reg [3], cand_vel_next [3];
    logic [MAG_W-1:0]         o_mag_reg [3], o_mag_next [3];
    logic                     o_neg_reg [3], o_neg_next [3];
    logic [MAG_W-1:0]         d_mag_reg [3], d_mag_next [3];
    logic                     d_neg_reg [3], d_neg_next [3];
    logic [POS_W-1:0]         st_reg [3], st_next [3];
    logic                     last_reg, last_next;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  a_reg, a_next;
    logic [OP_W-1:0]   b_reg, b_next;
    logic              sub_reg, sub_next;
    logic [S_W-1:0]    s_reg, s_next;
    logic [ACC_W-1:0]  tmp_reg, tmp_next;
    logic              dneg_reg, dneg_next;
    logic [1:0]        idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [OP_W-1:0]   num_reg, num_next;
    logic [OP_W-1:0]   rem_reg, rem_next;
    logic [OP_W-1:0]   quo_reg, quo_next;
    logic [OP_W-1:0]   den_reg, den_next;
    logic [OP_W-1:0]   bit_reg, bit_next;
    logic [LEN_W-1:0]  len_reg, len_next;

    logic                    out_valid_reg, out_valid_next;
    logic [POS_W-1:0]        ox_reg, oy_reg, oz_reg, ox_next, oy_next, oz_next;
    logic [CNT_W-1:0]        ocnt_reg, ocnt_next;
    logic                    ofound_reg, ofound_next;

    logic [ACC_W-1:0] alu_x, alu_y, alu_sum;
    logic             alu_sub, alu_ge;

    logic signed [POS_W-1:0]  in_pos [3];
    logic signed [POS_W-1:0]  in_vel [3];
    logic signed [LOOK_W-1:0] in_look [3];
    logic                     accept_in;
    logic                     is_last_idx;
    logic [1:0]               idx_inc;
    logic [OP_W-1:0]          div_r1;
    logic [LOOK_W-1:0]        look_mag;
    logic [LOOK_W-1:0]        m_mag;
    logic                     m_le0;
    logic                     m_off;
    logic [SUM_W-1:0]         vsum_mag;
    logic signed [MAG_W:0]    avg_s;
    logic signed [MAG_W:0]    d_s;
    logic signed [MAG_W-1:0]  o_s [3];

    assign in_pos[0]  = pos_x;
    assign in_pos[1]  = pos_y;
    assign in_pos[2]  = pos_z;
    assign in_vel[0]  = vel_x;
    assign in_vel[1]  = vel_y;
    assign in_vel[2]  = vel_z;
    assign in_look[0] = look_x;
    assign in_look[1] = look_y;
    assign in_look[2] = look_z;

    assign in_ready        = (state_reg == ST_IDLE);
    assign accept_in       = in_valid & in_ready;
    assign out_valid       = out_valid_reg;
    assign steer_x         = ox_reg;
    assign steer_y         = oy_reg;
    assign steer_z         = oz_reg;
    assign neighbour_count = ocnt_reg;
    assign found           = ofound_reg;

    assign is_last_idx = (idx_reg == 2'd2);
    assign idx_inc     = is_last_idx ? 2'd0 : idx_reg + 2'd1;
    assign div_r1      = {rem_reg[OP_W-2:0], num_reg[OP_W-1]};
    assign m_le0       = (cfg.min_dot <= 16'sd0);
    assign m_off       = (cfg.min_dot <= DOT_OFF);
    assign m_mag       = cfg.min_dot[LOOK_W-1] ? LOOK_W'(-cfg.min_dot)
                                               : cfg.min_dot;
    assign look_mag    = own_look_reg[idx_reg][LOOK_W-1]
                       ? LOOK_W'(-own_look_reg[idx_reg]) : own_look_reg[idx_reg];
    assign vsum_mag    = vsum_reg[idx_reg][SUM_W-1]
                       ? SUM_W'(-vsum_reg[idx_reg]) : vsum_reg[idx_reg];
    assign avg_s       = vsum_reg[idx_reg][SUM_W-1]
                       ? -$signed({1'b0, quo_reg[MAG_W-1:0]})
                       : $signed({1'b0, quo_reg[MAG_W-1:0]});
    assign d_s         = avg_s - (MAG_W+1)'(own_vel_reg[idx_reg]);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            o_s[i] = MAG_W'(in_pos[i]) - MAG_W'(own_pos_reg[i]);
    end

    fva_addsub u_alu (
        .x     (alu_x),
        .y     (alu_y),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_ge)
    );

    // shared adder operand select
    always_comb
    begin
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            ST_MUL:
            begin
                alu_x   = acc_reg;
                alu_y   = a_reg;
                alu_sub = sub_reg;
            end
            ST_DIV:
            begin
                alu_x   = ACC_W'(div_r1);
                alu_y   = ACC_W'(den_reg);
                alu_sub = 1'b1;
            end
            ST_SQRT:
            begin
                alu_x   = ACC_W'(rem_reg);
                alu_y   = ACC_W'(quo_reg | bit_reg);
                alu_sub = 1'b1;
            end
            ST_R2_CMP, ST_A2_CMP:
            begin
                alu_x   = acc_reg;
                alu_y   = ACC_W'(s_reg);
                alu_sub = 1'b1;
            end
            ST_CONE_CMP:
            begin
                alu_x   = dneg_reg ? acc_reg : tmp_reg;
                alu_y   = dneg_reg ? tmp_reg : acc_reg;
                alu_sub = 1'b1;
            end
            ST_D_ABS:
            begin
                alu_y   = acc_reg;
                alu_sub = acc_reg[ACC_W-1];
            end
            ST_AVG_SET:
            begin
                alu_x = ACC_W'(vsum_mag);
                alu_y = ACC_W'(cnt_reg >> 1);
            end
            ST_DIV_SET:
            begin
                alu_x = acc_reg;
                alu_y = ACC_W'(len_reg >> 1);
            end
            default:
            begin
                alu_sub = 1'b0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    if (mode)
                        state_next = ST_SQ_SET;
                    else if (last)
                        state_next = ST_FIN;
                end
            end
            ST_SQ_SET, ST_R2_SET, ST_D_SET, ST_M_SET, ST_MS_SET,
            ST_MAG_SET, ST_A2_SET, ST_NUM_SET:
                state_next = ST_MUL;
            ST_R2_CMP:   state_next = alu_ge ? ST_CONE : ST_ITEM_END;
            ST_CONE:
            begin
                if (m_off)
                    state_next = ST_ACCEPT;
                else if (s_reg == '0)
                    state_next = m_le0 ? ST_ACCEPT : ST_ITEM_END;
                else
                    state_next = ST_D_SET;
            end
            ST_D_ABS:
            begin
                if (!acc_reg[ACC_W-1] && m_le0)
                    state_next = ST_ACCEPT;
                else if (acc_reg[ACC_W-1] && !m_le0)
                    state_next = ST_ITEM_END;
                else
                    state_next = ST_MUL;
            end
            ST_CONE_CMP: state_next = alu_ge ? ST_ACCEPT : ST_ITEM_END;
            ST_ACCEPT:   state_next = ST_ITEM_END;
            ST_ITEM_END: state_next = last_reg ? ST_FIN : ST_IDLE;
            ST_FIN:      state_next = (cnt_reg == '0) ? ST_EMIT : ST_AVG_SET;
            ST_AVG_SET:  state_next = ST_DIV;
            ST_AVG_DONE: state_next = is_last_idx ? ST_MAG_SET : ST_AVG_SET;
            ST_A2_CMP:   state_next = alu_ge ? ST_EMIT : ST_SQRT_SET;
            ST_SQRT_SET: state_next = ST_SQRT;
            ST_SQRT_DONE: state_next = ST_NUM_SET;
            ST_DIV_SET:  state_next = ST_DIV;
            ST_DIV_DONE: state_next = is_last_idx ? ST_EMIT : ST_NUM_SET;
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = ST_IDLE;
            end
            ST_MUL:
            begin
                if (b_reg == '0)
                    state_next = ret_reg;
            end
            ST_DIV:
            begin
                if (step_reg == DIV_LAST)
                    state_next = ret_reg;
            end
            ST_SQRT:
            begin
                if (step_reg == SQRT_LAST)
                    state_next = ret_reg;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        own_pos_next  = own_pos_reg;
        own_vel_next  = own_vel_reg;
        own_look_next = own_look_reg;
        vsum_next     = vsum_reg;
        cnt_next      = cnt_reg;
        cand_vel_next = cand_vel_reg;
        o_mag_next    = o_mag_reg;
        o_neg_next    = o_neg_reg;
        d_mag_next    = d_mag_reg;
        d_neg_next    = d_neg_reg;
        st_next       = st_reg;
        last_next     = last_reg;
        ret_next      = ret_reg;
        acc_next      = acc_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        sub_next      = sub_reg;
        s_next        = s_reg;
        tmp_next      = tmp_reg;
        dneg_next     = dneg_reg;
        idx_next      = idx_reg;
        step_next     = step_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        den_next      = den_reg;
        bit_next      = bit_reg;
        len_next      = len_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        ox_next       = ox_reg;
        oy_next       = oy_reg;
        oz_next       = oz_reg;
        ocnt_next     = ocnt_reg;
        ofound_next   = ofound_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept_in)
                begin
                    if (!mode)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            own_pos_next[i]  = in_pos[i];
                            own_vel_next[i]  = in_vel[i];
                            own_look_next[i] = in_look[i];
                            vsum_next[i]     = '0;
                        end
                        cnt_next = '0;
                    end
                    else
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            cand_vel_next[i] = in_vel[i];
                            o_neg_next[i]    = o_s[i][MAG_W-1];
                            o_mag_next[i]    = o_s[i][MAG_W-1] ? MAG_W'(-o_s[i])
                                                               : o_s[i];
                        end
                        last_next = last;
                        acc_next  = '0;
                        idx_next  = 2'd0;
                    end
                end
            end
            ST_SQ_SET:
            begin
                a_next   = ACC_W'(o_mag_reg[idx_reg]);
                b_next   = OP_W'(o_mag_reg[idx_reg]);
                sub_next = 1'b0;
                ret_next = is_last_idx ? ST_R2_SET : ST_SQ_SET;
                idx_next = idx_inc;
            end
            ST_R2_SET:
            begin
                s_next   = acc_reg[S_W-1:0];
                a_next   = ACC_W'(cfg.radius);
                b_next   = OP_W'(cfg.radius);
                sub_next = 1'b0;
                acc_next = '0;
                ret_next = ST_R2_CMP;
            end
            ST_CONE:
            begin
                acc_next = '0;
                idx_next = 2'd0;
            end
            ST_D_SET:
            begin
                a_next   = ACC_W'(look_mag);
                b_next   = OP_W'(o_mag_reg[idx_reg]);
                sub_next = own_look_reg[idx_reg][LOOK_W-1] ^ o_neg_reg[idx_reg];
                ret_next = is_last_idx ? ST_D_ABS : ST_D_SET;
                idx_next = idx_inc;
            end
            ST_D_ABS:
            begin
                dneg_next = acc_reg[ACC_W-1];
                a_next    = alu_sum;
                b_next    = alu_sum[OP_W-1:0];
                sub_next  = 1'b0;
                acc_next  = '0;
                ret_next  = ST_M_SET;
            end
            ST_M_SET:
            begin
                tmp_next = acc_reg;
                a_next   = ACC_W'(m_mag);
                b_next   = OP_W'(m_mag);
                sub_next = 1'b0;
                acc_next = '0;
                ret_next = ST_MS_SET;
            end
            ST_MS_SET:
            begin
                a_next   = ACC_W'(s_reg);
                b_next   = acc_reg[OP_W-1:0];
                sub_next = 1'b0;
                acc_next = '0;
                ret_next = ST_CONE_CMP;
            end
            ST_ACCEPT:
            begin
                if (cnt_reg < CNT_MAX)
                begin
                    for (int i = 0; i < 3; i++)
                        vsum_next[i] = vsum_reg[i] + SUM_W'(cand_vel_reg[i]);
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                idx_next = 2'd0;
                for (int i = 0; i < 3; i++)
                    st_next[i] = '0;
            end
            ST_AVG_SET:
            begin
                num_next  = alu_sum[OP_W-1:0];
                den_next  = OP_W'(cnt_reg);
                rem_next  = '0;
                quo_next  = '0;
                step_next = '0;
                ret_next  = ST_AVG_DONE;
            end
            ST_AVG_DONE:
            begin
                d_neg_next[idx_reg] = d_s[MAG_W];
                d_mag_next[idx_reg] = d_s[MAG_W] ? MAG_W'(-d_s) : d_s[MAG_W-1:0];
                if (is_last_idx)
                    acc_next = '0;
                idx_next = idx_inc;
            end
            ST_MAG_SET:
            begin
                a_next   = ACC_W'(d_mag_reg[idx_reg]);
                b_next   = OP_W'(d_mag_reg[idx_reg]);
                sub_next = 1'b0;
                ret_next = is_last_idx ? ST_A2_SET : ST_MAG_SET;
                idx_next = idx_inc;
            end
            ST_A2_SET:
            begin
                s_next   = acc_reg[S_W-1:0];
                a_next   = ACC_W'(cfg.max_acc);
                b_next   = OP_W'(cfg.max_acc);
                sub_next = 1'b0;
                acc_next = '0;
                ret_next = ST_A2_CMP;
            end
            ST_A2_CMP:
            begin
                if (alu_ge)
                begin
                    for (int i = 0; i < 3; i++)
                        st_next[i] = sat_steer(OP_W'(d_mag_reg[i]), d_neg_reg[i]);
                end
            end
            ST_SQRT_SET:
            begin
                rem_next  = {s_reg, 10'b0, {(OP_W-S_W-10){1'b0}}} >> (OP_W-S_W-10);
                quo_next  = '0;
                bit_next  = OP_W'(1) << (OP_W - 2);
                step_next = '0;
                ret_next  = ST_SQRT_DONE;
            end
            ST_SQRT_DONE:
            begin
                len_next = quo_reg[LEN_W-1:0];
                idx_next = 2'd0;
            end
            ST_NUM_SET:
            begin
                a_next   = ACC_W'({d_mag_reg[idx_reg], 5'b0});
                b_next   = OP_W'(cfg.max_acc);
                sub_next = 1'b0;
                acc_next = '0;
                ret_next = ST_DIV_SET;
            end
            ST_DIV_SET:
            begin
                num_next  = alu_sum[OP_W-1:0];
                den_next  = OP_W'(len_reg);
                rem_next  = '0;
                quo_next  = '0;
                step_next = '0;
                ret_next  = ST_DIV_DONE;
            end
            ST_DIV_DONE:
            begin
                st_next[idx_reg] = sat_steer(quo_reg, d_neg_reg[idx_reg]);
                idx_next = idx_inc;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    ox_next        = st_reg[0];
                    oy_next        = st_reg[1];
                    oz_next        = st_reg[2];
                    ocnt_next      = cnt_reg;
                    ofound_next    = (cnt_reg != '0);
                    for (int i = 0; i < 3; i++)
                        vsum_next[i] = '0;
                    cnt_next = '0;
                end
            end
            ST_MUL:
            begin
                if (b_reg != '0)
                begin
                    if (b_reg[0])
                        acc_next = alu_sum;
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
            end
            ST_DIV:
            begin
                rem_next  = alu_ge ? alu_sum[OP_W-1:0] : div_r1;
                quo_next  = {quo_reg[OP_W-2:0], alu_ge};
                num_next  = num_reg << 1;
                step_next = step_reg + 1'b1;
            end
            ST_SQRT:
            begin
                if (alu_ge)
                begin
                    rem_next = alu_sum[OP_W-1:0];
                    quo_next = (quo_reg >> 1) | bit_reg;
                end
                else
                begin
                    quo_next = quo_reg >> 1;
                end
                bit_next  = bit_reg >> 2;
                step_next = step_reg + 1'b1;
            end
            default:
            begin
                last_next = last_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            for (int i = 0; i < 3; i++)
            begin
                own_pos_reg[i]  <= '0;
                own_vel_reg[i]  <= '0;
                own_look_reg[i] <= '0;
                vsum_reg[i]     <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            own_pos_reg   <= own_pos_next;
            own_vel_reg   <= own_vel_next;
            own_look_reg  <= own_look_next;
            vsum_reg      <= vsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg      <= ret_next;
        cand_vel_reg <= cand_vel_next;
        o_mag_reg    <= o_mag_next;
        o_neg_reg    <= o_neg_next;
        d_mag_reg    <= d_mag_next;
        d_neg_reg    <= d_neg_next;
        st_reg       <= st_next;
        last_reg     <= last_next;
        acc_reg      <= acc_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        sub_reg      <= sub_next;
        s_reg        <= s_next;
        tmp_reg      <= tmp_next;
        dneg_reg     <= dneg_next;
        idx_reg      <= idx_next;
        step_reg     <= step_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        den_reg      <= den_next;
        bit_reg      <= bit_next;
        len_reg      <= len_next;
        ox_reg       <= ox_next;
        oy_reg       <= oy_next;
        oz_reg       <= oz_next;
        ocnt_reg     <= ocnt_next;
        ofound_reg   <= ofound_next;
    end

endmodule
`default_nettype wire

FILE: sv/flock_velocity_alignment.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flock_velocity_alignment
// Boids alignment steering for one boid: neighbour filtering by radius and
// view cone, velocity averaging, clamped and saturated steering output.
//
// channel  dir  handshake              beat
// in       in   in_valid / in_ready    mode, pos, vel, look, last
// out      out  out_valid / out_ready  steer_x/y/z, neighbour_count, found
// cfg      in   APB psel/penable       radius, min_dot, max_acceleration
//
// One item at a time; in_ready is high only while the sequencer is idle.
// Every product runs on one shared 96 bit adder as shift-add, one step per
// bit of the multiplier operand; a last item adds three averaging divides,
// the squares and, when the steering exceeds the cap, a root and three
// clamp steps.
// A result waits in the output register; the next query proceeds meanwhile
// until its own result is due. Reset restores register defaults and clears
// own values, sums and count.
// ----------------------------------------------------------------------------
module flock_velocity_alignment #(
    parameter int MAX_BOIDS = 256
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [fva_pkg::ADDR_W-1:0]          paddr,
    input  wire logic [fva_pkg::DATA_W-1:0]          pwdata,
    output logic [fva_pkg::DATA_W-1:0]               prdata,
    output logic                                     pready,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                mode,
    input  wire logic signed [fva_pkg::POS_W-1:0]    pos_x,
    input  wire logic signed [fva_pkg::POS_W-1:0]    pos_y,
    input  wire logic signed [fva_pkg::POS_W-1:0]    pos_z,
    input  wire logic signed [fva_pkg::POS_W-1:0]    vel_x,
    input  wire logic signed [fva_pkg::POS_W-1:0]    vel_y,
    input  wire logic signed [fva_pkg::POS_W-1:0]    vel_z,
    input  wire logic signed [fva_pkg::LOOK_W-1:0]   look_x,
    input  wire logic signed [fva_pkg::LOOK_W-1:0]   look_y,
    input  wire logic signed [fva_pkg::LOOK_W-1:0]   look_z,
    input  wire logic                                last,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [fva_pkg::POS_W-1:0]         steer_x,
    output logic signed [fva_pkg::POS_W-1:0]         steer_y,
    output logic signed [fva_pkg::POS_W-1:0]         steer_z,
    output logic [$clog2(MAX_BOIDS+1)-1:0]           neighbour_count,
    output logic                                     found
);
    import fva_pkg::*;

    cfg_t cfg;

    fva_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fva_core #(
        .MAX_BOIDS (MAX_BOIDS)
    ) u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .vel_x           (vel_x),
        .vel_y           (vel_y),
        .vel_z           (vel_z),
        .look_x          (look_x),
        .look_y          (look_y),
        .look_z          (look_z),
        .last            (last),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .steer_x         (steer_x),
        .steer_y         (steer_y),
        .steer_z         (steer_z),
        .neighbour_count (neighbour_count),
        .found           (found)
    );

endmodule
`default_nettype wire
